### src/nbi_pkg.sv
// Shared constants, codes and fixed-point helpers for the body integrator.
`timescale 1ns / 1ps
package nbi_pkg;

	localparam int FRAC_BITS   = 24;
	localparam int COORD_WIDTH = 64;
	localparam int LANES       = 3;

	localparam logic [63:0] CMAX_U = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;
	localparam logic signed [63:0] CMAX = signed'(CMAX_U);
	localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;
	localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;
	localparam logic [62:0] M63 = '1;
	localparam logic [62:0] ONE_FIX = 63'd1 << FRAC_BITS;

	localparam logic [2:0] FN_LOAD    = 3'd0;
	localparam logic [2:0] FN_CLEAR   = 3'd1;
	localparam logic [2:0] FN_ADD     = 3'd2;
	localparam logic [2:0] FN_ADVANCE = 3'd3;
	localparam logic [2:0] FN_LATCH   = 3'd4;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_SKIP = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	localparam logic [1:0] REG_GRAV = 2'd0;
	localparam logic [1:0] REG_DT   = 2'd1;

	typedef struct packed {
		logic signed [63:0] val;
		logic               sat;
	} sval_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic sval_t clamp65(input logic signed [64:0] a,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		sval_t r;
		logic signed [64:0] lo_x;
		logic signed [64:0] hi_x;
		lo_x = 65'(lo);
		hi_x = 65'(hi);
		if (a > hi_x) begin
			r.val = hi;
			r.sat = 1'b1;
		end else if (a < lo_x) begin
			r.val = lo;
			r.sat = 1'b1;
		end else begin
			r.val = a[63:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	function automatic sval_t sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b, input logic signed [63:0] lo,
			input logic signed [63:0] hi);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		return clamp65(s, lo, hi);
	endfunction

	function automatic sval_t sat_sub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		return clamp65(s, SMIN, SMAX);
	endfunction

	// magnitude plus sign back to int64, clamping
	function automatic sval_t make_signed(input logic neg, input logic [127:0] m);
		sval_t r;
		logic [63:0] limit;
		limit = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if ((|m[127:64]) || (m[63:0] > limit)) begin
			r.val = neg ? SMIN : SMAX;
			r.sat = 1'b1;
		end else begin
			r.val = neg ? signed'(~m[63:0] + 64'd1) : signed'(m[63:0]);
			r.sat = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [127:0] shl_frac(input logic [63:0] x);
		return {64'd0, x} << FRAC_BITS;
	endfunction

endpackage

### src/nbi_mul.sv
// Unsigned 64x64 multiplier, one 32x32 partial product per cycle.
`timescale 1ns / 1ps
module nbi_mul import nbi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);

	logic [63:0]  a_q, b_q;
	logic [127:0] prod_q;
	logic [1:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [127:0] term;

	always_comb begin
		ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp = {32'd0, ah} * {32'd0, bh};
		case (cnt_q)
			2'd0:    term = {64'd0, pp};
			2'd3:    term = {pp, 64'd0};
			default: term = {32'd0, pp, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= prod_q + term;
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

### src/nbi_div.sv
// Restoring 128/64 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module nbi_div import nbi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic         done,
	output logic [127:0] quot
);

	logic [127:0] n_q;
	logic [63:0]  rem_q, den_q, rem_nx;
	logic [6:0]   cnt_q;
	logic         busy_q, done_q, ge;
	logic [64:0]  rem_sh, diff;

	always_comb begin
		rem_sh = {rem_q, n_q[127]};
		ge     = rem_sh >= {1'b0, den_q};
		diff   = rem_sh - {1'b0, den_q};
		rem_nx = ge ? diff[63:0] : rem_sh[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			n_q   <= {n_q[126:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

### src/nbi_sqrt.sv
// Integer square root of a 128-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps
module nbi_sqrt import nbi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] rad,
	output logic         done,
	output logic [63:0]  root
);

	logic [127:0] s_q;
	logic [65:0]  rem_q;
	logic [63:0]  root_q;
	logic [5:0]   cnt_q;
	logic         busy_q, done_q, ge;
	logic [67:0]  rem_sh, trial, diff;

	always_comb begin
		rem_sh = {rem_q, s_q[127:126]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = rem_sh >= trial;
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			s_q    <= {s_q[125:0], 2'b00};
			rem_q  <= ge ? diff[65:0] : rem_sh[65:0];
			root_q <= {root_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### src/nbody_body_integrator.sv
// Top level: one gravity body with three axis lanes, a merge stage and a sequencer.
`timescale 1ns / 1ps
// One body of a direct-sum gravity simulation in signed fixed point
// (FRAC_BITS fraction bits). Each input word carries one operation: load,
// clear acceleration, add source, advance (semi-implicit Euler) or latch the
// previous position; each accepted word yields exactly one result word with
// position, velocity, G^2*|a|^2 and a status code. Three axis lanes, each
// with a serial 64x64 multiplier (one 32x32 partial product per cycle) and a
// serial 128/64 divider (one quotient bit per cycle), work side by side; a
// merge stage sums the lane squares and runs the shared square root (two
// radicand bits per cycle). Words are taken one at a time. Every operation
// ends with the G*a and squaring multiply steps; advance first runs the
// acceleration, velocity and position steps, and add source first runs the
// lane squares, the root, three divider passes and the term step, skipping
// from the squares to the end for a source at zero distance. A finished
// result sits in an output register, so the next word is taken while it
// waits. Configuration writes are for idle periods only; index values above
// 1 are ignored.
module nbody_body_integrator import nbi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [62:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [63:0] in_pos_x,
	input  logic signed [63:0] in_pos_y,
	input  logic signed [63:0] in_pos_z,
	input  logic signed [63:0] in_vel_x,
	input  logic signed [63:0] in_vel_y,
	input  logic signed [63:0] in_vel_z,
	input  logic [62:0]        src_mass,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] out_pos_x,
	output logic signed [63:0] out_pos_y,
	output logic signed [63:0] out_pos_z,
	output logic signed [63:0] out_vel_x,
	output logic signed [63:0] out_vel_y,
	output logic signed [63:0] out_vel_z,
	output logic [62:0]        gravity_sq,
	output logic [1:0]         status
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SQ     = 4'd1;
	localparam logic [3:0] ST_SUM    = 4'd2;
	localparam logic [3:0] ST_ROOT   = 4'd3;
	localparam logic [3:0] ST_Q1     = 4'd4;
	localparam logic [3:0] ST_Q2     = 4'd5;
	localparam logic [3:0] ST_U      = 4'd6;
	localparam logic [3:0] ST_TERM   = 4'd7;
	localparam logic [3:0] ST_ADV_A  = 4'd8;
	localparam logic [3:0] ST_ADV_DV = 4'd9;
	localparam logic [3:0] ST_ADV_DP = 4'd10;
	localparam logic [3:0] ST_G_A    = 4'd11;
	localparam logic [3:0] ST_G_SQ   = 4'd12;
	localparam logic [3:0] ST_DONE   = 4'd13;

	logic [3:0] state_q;
	logic       go_q;          // first cycle of a unit state: kick the units
	logic       sat_q, skip_q;

	// architectural state, one entry per axis
	logic signed [63:0] pos_q [LANES];
	logic signed [63:0] prev_q [LANES];
	logic signed [63:0] vel_q [LANES];
	logic signed [63:0] acc_q [LANES];

	// working registers
	logic signed [63:0] d_q [LANES];
	logic signed [63:0] tmp_q [LANES];
	logic [63:0]        u_q [LANES];
	logic [62:0]        mass_q, grav_q, dt_q;
	logic [63:0]        r_q, q1_q, q2_q;
	logic [127:0]       g_q;

	logic signed [63:0] out_pos_q [LANES];
	logic signed [63:0] out_vel_q [LANES];
	logic [62:0]        out_gs_q;
	logic [1:0]         out_stat_q;
	logic               out_valid_q;

	logic signed [63:0] in_pos [LANES];
	logic signed [63:0] in_vel [LANES];

	// lane units
	logic [LANES-1:0]   mul_start, mul_done, div_start, div_done;
	logic [63:0]        mul_a [LANES];
	logic [63:0]        mul_b [LANES];
	logic [127:0]       mul_p [LANES];
	logic [127:0]       div_n [LANES];
	logic [127:0]       div_q [LANES];
	logic               sqrt_start, sqrt_done;
	logic [63:0]        sqrt_root;

	// per-lane combinational results
	sval_t              src_c [LANES];
	sval_t              d_s [LANES];
	sval_t              ld_c [LANES];
	sval_t              ms [LANES];
	sval_t              lane_sum [LANES];
	logic [LANES-1:0]   ms_neg, in_sat, lane_sat;
	logic signed [63:0] sum_base [LANES];
	logic signed [63:0] sum_lo, sum_hi;

	// merge stage
	logic [127:0]       sq_sum, g_sum;
	logic               unit_st, accept, out_free;
	logic [63:0]        q_sat_val;
	logic               q_sat;

	assign in_pos[0] = in_pos_x;
	assign in_pos[1] = in_pos_y;
	assign in_pos[2] = in_pos_z;
	assign in_vel[0] = in_vel_x;
	assign in_vel[1] = in_vel_y;
	assign in_vel[2] = in_vel_z;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		unit_st = 1'b0;
		case (state_q)
			ST_SQ, ST_TERM, ST_ADV_A, ST_ADV_DV, ST_ADV_DP, ST_G_A, ST_G_SQ: unit_st = 1'b1;
			default: unit_st = 1'b0;
		endcase
	end

	always_comb begin
		sum_lo = SMIN;
		sum_hi = SMAX;
		if (state_q == ST_ADV_DP) begin
			sum_lo = CMIN;
			sum_hi = CMAX;
		end
		for (int i = 0; i < LANES; i++) begin
			src_c[i] = clamp65(65'(in_pos[i]), CMIN, CMAX);
			d_s[i]   = sat_sub(src_c[i].val, pos_q[i]);
			ld_c[i]  = src_c[i];
			in_sat[i] = src_c[i].sat | ((func == FN_ADD) & d_s[i].sat);

			mul_a[i]  = '0;
			mul_b[i]  = '0;
			ms_neg[i] = 1'b0;
			sum_base[i] = acc_q[i];
			case (state_q)
				ST_SQ: begin
					mul_a[i] = mag64(d_q[i]);
					mul_b[i] = mag64(d_q[i]);
				end
				ST_TERM: begin
					mul_a[i]  = q2_q;
					mul_b[i]  = u_q[i];
					ms_neg[i] = d_q[i][63];
				end
				ST_ADV_A, ST_G_A: begin
					mul_a[i]  = mag64(acc_q[i]);
					mul_b[i]  = {1'b0, grav_q};
					ms_neg[i] = acc_q[i][63];
				end
				ST_ADV_DV: begin
					mul_a[i]  = mag64(tmp_q[i]);
					mul_b[i]  = {1'b0, dt_q};
					ms_neg[i] = tmp_q[i][63];
					sum_base[i] = vel_q[i];
				end
				ST_ADV_DP: begin
					mul_a[i]  = mag64(vel_q[i]);
					mul_b[i]  = {1'b0, dt_q};
					ms_neg[i] = vel_q[i][63];
					sum_base[i] = pos_q[i];
				end
				ST_G_SQ: begin
					mul_a[i] = mag64(tmp_q[i]);
					mul_b[i] = mag64(tmp_q[i]);
				end
				default: begin
					mul_a[i] = '0;
				end
			endcase
			mul_start[i] = go_q && unit_st;

			case (state_q)
				ST_Q1:   div_n[i] = shl_frac({1'b0, mass_q});
				ST_Q2:   div_n[i] = shl_frac(q1_q);
				default: div_n[i] = shl_frac(mag64(d_q[i]));
			endcase
			div_start[i] = go_q && ((state_q == ST_U) ||
				((i == 0) && ((state_q == ST_Q1) || (state_q == ST_Q2))));

			ms[i]       = make_signed(ms_neg[i], mul_p[i] >> FRAC_BITS);
			lane_sum[i] = sat_add(sum_base[i], ms[i].val, sum_lo, sum_hi);
			lane_sat[i] = ms[i].sat | (((state_q == ST_TERM) || (state_q == ST_ADV_DV) ||
				(state_q == ST_ADV_DP)) & lane_sum[i].sat);
		end
		sqrt_start = go_q && (state_q == ST_ROOT);
		sq_sum = mul_p[0] + mul_p[1] + mul_p[2];
		g_sum  = (mul_p[0] >> FRAC_BITS) + (mul_p[1] >> FRAC_BITS) +
			(mul_p[2] >> FRAC_BITS);
		q_sat     = |div_q[0][127:64];
		q_sat_val = q_sat ? '1 : div_q[0][63:0];
	end

	for (genvar gi = 0; gi < LANES; gi++) begin : g_lane
		nbi_mul u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (mul_start[gi]),
			.a      (mul_a[gi]),
			.b      (mul_b[gi]),
			.done   (mul_done[gi]),
			.prod   (mul_p[gi])
		);
		nbi_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start[gi]),
			.num    (div_n[gi]),
			.den    (r_q),
			.done   (div_done[gi]),
			.quot   (div_q[gi])
		);
	end

	nbi_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sq_sum),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= ONE_FIX;
			dt_q   <= ONE_FIX;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GRAV: grav_q <= cfg_data;
				REG_DT:   dt_q   <= cfg_data;
				default:  ;
			endcase
		end
	end

	// sequencer and body state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			sat_q       <= 1'b0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				pos_q[i]  <= '0;
				prev_q[i] <= '0;
				vel_q[i]  <= '0;
				acc_q[i]  <= '0;
			end
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sat_q  <= 1'b0;
						skip_q <= 1'b0;
						go_q   <= 1'b1;
						state_q <= ST_G_A;
						case (func)
							FN_LOAD: begin
								sat_q <= |in_sat;
								for (int i = 0; i < LANES; i++) begin
									pos_q[i]  <= ld_c[i].val;
									prev_q[i] <= ld_c[i].val;
									vel_q[i]  <= in_vel[i];
								end
							end
							FN_CLEAR: begin
								for (int i = 0; i < LANES; i++) acc_q[i] <= '0;
							end
							FN_ADD: begin
								sat_q   <= |in_sat;
								state_q <= ST_SQ;
							end
							FN_ADVANCE: state_q <= ST_ADV_A;
							FN_LATCH: begin
								for (int i = 0; i < LANES; i++) prev_q[i] <= pos_q[i];
							end
							default: ;
						endcase
					end
				end
				ST_SQ: if (mul_done[0]) state_q <= ST_SUM;
				ST_SUM: begin
					go_q <= 1'b1;
					if (sq_sum == '0) begin
						skip_q  <= 1'b1;
						state_q <= ST_G_A;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: if (sqrt_done) begin
					go_q    <= 1'b1;
					state_q <= ST_Q1;
				end
				ST_Q1: if (div_done[0]) begin
					sat_q   <= sat_q | q_sat;
					go_q    <= 1'b1;
					state_q <= ST_Q2;
				end
				ST_Q2: if (div_done[0]) begin
					sat_q   <= sat_q | q_sat;
					go_q    <= 1'b1;
					state_q <= ST_U;
				end
				ST_U: if (div_done[0]) begin
					go_q    <= 1'b1;
					state_q <= ST_TERM;
				end
				ST_TERM: if (mul_done[0]) begin
					for (int i = 0; i < LANES; i++) acc_q[i] <= lane_sum[i].val;
					sat_q   <= sat_q | (|lane_sat);
					go_q    <= 1'b1;
					state_q <= ST_G_A;
				end
				ST_ADV_A: if (mul_done[0]) begin
					sat_q   <= sat_q | (|lane_sat);
					go_q    <= 1'b1;
					state_q <= ST_ADV_DV;
				end
				ST_ADV_DV: if (mul_done[0]) begin
					for (int i = 0; i < LANES; i++) vel_q[i] <= lane_sum[i].val;
					sat_q   <= sat_q | (|lane_sat);
					go_q    <= 1'b1;
					state_q <= ST_ADV_DP;
				end
				ST_ADV_DP: if (mul_done[0]) begin
					for (int i = 0; i < LANES; i++) pos_q[i] <= lane_sum[i].val;
					sat_q   <= sat_q | (|lane_sat);
					go_q    <= 1'b1;
					state_q <= ST_G_A;
				end
				ST_G_A: if (mul_done[0]) begin
					sat_q   <= sat_q | (|lane_sat);
					go_q    <= 1'b1;
					state_q <= ST_G_SQ;
				end
				ST_G_SQ: if (mul_done[0]) state_q <= ST_DONE;
				ST_DONE: if (out_free) begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working and output payload registers
	always_ff @(posedge clk) begin
		if (accept) mass_q <= src_mass;
		for (int i = 0; i < LANES; i++) begin
			if (accept) d_q[i] <= d_s[i].val;
			if ((state_q == ST_U) && div_done[0]) u_q[i] <= div_q[i][63:0];
			if (((state_q == ST_ADV_A) || (state_q == ST_G_A)) && mul_done[0])
				tmp_q[i] <= ms[i].val;
		end
		if ((state_q == ST_ROOT) && sqrt_done) r_q <= sqrt_root;
		if ((state_q == ST_Q1) && div_done[0]) q1_q <= q_sat_val;
		if ((state_q == ST_Q2) && div_done[0]) q2_q <= q_sat_val;
		if ((state_q == ST_G_SQ) && mul_done[0]) g_q <= g_sum;
		if ((state_q == ST_DONE) && out_free) begin
			for (int i = 0; i < LANES; i++) begin
				out_pos_q[i] <= pos_q[i];
				out_vel_q[i] <= vel_q[i];
			end
			out_gs_q <= (g_q > {65'd0, M63}) ? M63 : g_q[62:0];
			if (skip_q)
				out_stat_q <= STAT_SKIP;
			else if (sat_q || (g_q > {65'd0, M63}))
				out_stat_q <= STAT_SAT;
			else
				out_stat_q <= STAT_OK;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_pos_x  = out_pos_q[0];
	assign out_pos_y  = out_pos_q[1];
	assign out_pos_z  = out_pos_q[2];
	assign out_vel_x  = out_vel_q[0];
	assign out_vel_y  = out_vel_q[1];
	assign out_vel_z  = out_vel_q[2];
	assign gravity_sq = out_gs_q;
	assign status     = out_stat_q;

	// lanes run in lockstep
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done[0] |-> (mul_done[1] && mul_done[2]))
		else $error("multiplier lanes out of step");

	// multiplier finishes only where the sequencer waits for it
	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done[0] |-> unit_st)
		else $error("multiplier result with no consumer");

	// divider never sees a zero root
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q1 || state_q == ST_Q2 || state_q == ST_U) |-> (r_q != '0))
		else $error("division by zero root");

	// no status code beyond the defined three
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_stat_q != 2'd3))
		else $error("undefined status code");

endmodule
